### rtl/core/pnghs_pkg.sv
// ----------------------------------------------------------------------------
// PNG header scanner package
// Shared constants, result codes and decode types for the PNG header scanner.
// ----------------------------------------------------------------------------
package pnghs_pkg;

	// Eight-byte file signature, first byte in the lowest bits.
	localparam logic [63:0] SIG_CODE = 64'h0a1a0a0d474e5089;

	// Chunk type words, first byte of the type in the lowest bits.
	localparam logic [31:0] TYPE_IHDR = 32'h52444849;
	localparam logic [31:0] TYPE_PLTE = 32'h45544c50;
	localparam logic [31:0] TYPE_TRNS = 32'h534e5274;
	localparam logic [31:0] TYPE_IDAT = 32'h54414449;

	// Header geometry.
	localparam int HDR_IDX_W = 6;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 6'd32;
	localparam logic [HDR_IDX_W-1:0] HDR_COLOUR_IDX = 6'd25;

	// Result status codes.
	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_SHORT = 2'd1;
	localparam logic [1:0] STATUS_BAD_SIG = 2'd2;
	localparam logic [1:0] STATUS_BAD_IHDR = 2'd3;

	// Per-byte decode flags handed from the decoder to the scanner control.
	typedef struct packed {
		logic sig_mismatch;
		logic ihdr_mismatch;
		logic width_byte;
		logic height_byte;
		logic colour_byte;
		logic header_end;
		logic is_idat;
		logic is_plte;
		logic is_trns;
	} byte_decode_t;

endpackage

### rtl/core/png_header_chunk_scanner.sv
// ----------------------------------------------------------------------------
// PNG header and chunk scanner
// Parses a PNG byte stream: signature, IHDR fields and the chunk list up to
// the first IDAT chunk, and reports one summary result per file.
// ----------------------------------------------------------------------------
// The scanner takes one file byte per request on the slave side, with tlast on
// the final byte of the file, and sustains one byte per clock cycle except while
// a byte that causes a result waits for the result register. Each byte passes
// through an input register and the compare and counter logic into the result
// register; an earlier result that still waits delays a later one.
// Bytes that cause no result keep flowing while a result waits; only a byte
// that causes a result is held in the input register until the result register
// is free. The first 33 bytes are checked as signature and IHDR chunk. A file
// that ends inside them gives status 1; a bad signature gives status 2 and a
// bad IHDR type status 3, both at the 33rd byte. Otherwise the chunk list is
// walked and one status 0 result is given at the first IDAT chunk or at the end
// of the file, carrying the image size, colour type, palette length and tRNS
// flag. After a result the remaining bytes are dropped until tlast, after which
// the scanner starts over for the next file. Chunk CRCs are not checked.
// ----------------------------------------------------------------------------
module png_header_chunk_scanner
	import pnghs_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [111:0] m_axis_tdata,   // [31:0] image_width, [63:32] image_height,
	                                     // [71:64] color_type, [103:72] palette_bytes,
	                                     // [104] has_transparency,
	                                     // [105] reached_image_data, [111:106] zero
	output logic [1:0]   m_axis_tuser    // [1:0] status
);

	// Scan phases.
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_CHUNK  = 2'd1;
	localparam logic [1:0] PH_SKIP   = 2'd2;
	localparam logic [1:0] PH_DONE   = 2'd3;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;

	// Scanner state.
	logic [1:0]           phase_q, phase_n;
	logic [HDR_IDX_W-1:0] idx_q, idx_n;
	logic [31:0]          len_q, len_n;
	logic [23:0]          type_q, type_n;
	logic [32:0]          skip_q, skip_n;
	logic [31:0]          width_q, width_n;
	logic [31:0]          height_q, height_n;
	logic [7:0]           colour_q, colour_n;
	logic [31:0]          pal_q, pal_n;
	logic                 trns_q, trns_n;
	logic                 sig_bad_q, sig_bad_n;
	logic                 ihdr_bad_q, ihdr_bad_n;

	// Result of the current byte.
	logic       emit;
	logic [1:0] res_status;
	logic       res_reached;

	// Result register.
	logic         out_valid_q;
	logic [111:0] out_data_q;
	logic [1:0]   out_status_q;

	byte_decode_t dec;

	// The input stage moves on whenever its byte causes no result, or the
	// result register is empty or is being drained in this cycle.
	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	pnghs_byte_decode u_decode (
		.idx      (idx_q),
		.data     (data_s1),
		.type_low (type_q),
		.dec      (dec)
	);

	// Next-state logic for one byte. Result fields are taken from the updated
	// state, so a PLTE or tRNS header completed by the final byte is included.
	always_comb begin
		phase_n     = phase_q;
		idx_n       = idx_q;
		len_n       = len_q;
		type_n      = type_q;
		skip_n      = skip_q;
		width_n     = width_q;
		height_n    = height_q;
		colour_n    = colour_q;
		pal_n       = pal_q;
		trns_n      = trns_q;
		sig_bad_n   = sig_bad_q | dec.sig_mismatch;
		ihdr_bad_n  = ihdr_bad_q | dec.ihdr_mismatch;
		emit        = 1'b0;
		res_status  = STATUS_OK;
		res_reached = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				if (dec.width_byte) begin
					width_n = {width_q[23:0], data_s1};
				end
				if (dec.height_byte) begin
					height_n = {height_q[23:0], data_s1};
				end
				if (dec.colour_byte) begin
					colour_n = data_s1;
				end
				if (dec.header_end) begin
					if (sig_bad_q) begin
						emit       = 1'b1;
						res_status = STATUS_BAD_SIG;
						phase_n    = PH_DONE;
					end else if (ihdr_bad_q) begin
						emit       = 1'b1;
						res_status = STATUS_BAD_IHDR;
						phase_n    = PH_DONE;
					end else begin
						phase_n = PH_CHUNK;
						idx_n   = '0;
						len_n   = '0;
						type_n  = '0;
						emit    = last_s1;
					end
				end else begin
					idx_n = idx_q + 6'd1;
					if (last_s1) begin
						emit       = 1'b1;
						res_status = STATUS_SHORT;
					end
				end
			end
			PH_CHUNK: begin
				// Length bytes come big-endian; the type word is gathered with its
				// first byte lowest so that it matches the type constants.
				if (!idx_q[2]) begin
					len_n = {len_q[23:0], data_s1};
				end else if (idx_q[1:0] != 2'd3) begin
					type_n = type_q | (24'(data_s1) << {idx_q[1:0], 3'b000});
				end
				if (idx_q[2:0] == 3'd7) begin
					if (dec.is_idat) begin
						emit        = 1'b1;
						res_reached = 1'b1;
						phase_n     = PH_DONE;
					end else begin
						if (dec.is_plte) begin
							pal_n = len_q;
						end else if (dec.is_trns) begin
							trns_n = 1'b1;
						end
						// Body plus the four CRC bytes.
						skip_n  = {1'b0, len_q} + 33'd4;
						phase_n = PH_SKIP;
						emit    = last_s1;
					end
				end else begin
					idx_n = idx_q + 6'd1;
					emit  = last_s1;
				end
			end
			PH_SKIP: begin
				if (skip_q > 33'd1) begin
					skip_n = skip_q - 33'd1;
				end else begin
					skip_n  = '0;
					phase_n = PH_CHUNK;
					idx_n   = '0;
					len_n   = '0;
					type_n  = '0;
				end
				emit = last_s1;
			end
			default: begin
				// Result already given: bytes are dropped until the end of file.
			end
		endcase
	end

	// Scanner state registers; the last byte of a file returns them to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			idx_q      <= '0;
			len_q      <= '0;
			type_q     <= '0;
			skip_q     <= '0;
			width_q    <= '0;
			height_q   <= '0;
			colour_q   <= '0;
			pal_q      <= '0;
			trns_q     <= 1'b0;
			sig_bad_q  <= 1'b0;
			ihdr_bad_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				phase_q    <= PH_HEADER;
				idx_q      <= '0;
				len_q      <= '0;
				type_q     <= '0;
				skip_q     <= '0;
				width_q    <= '0;
				height_q   <= '0;
				colour_q   <= '0;
				pal_q      <= '0;
				trns_q     <= 1'b0;
				sig_bad_q  <= 1'b0;
				ihdr_bad_q <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				idx_q      <= idx_n;
				len_q      <= len_n;
				type_q     <= type_n;
				skip_q     <= skip_n;
				width_q    <= width_n;
				height_q   <= height_n;
				colour_q   <= colour_n;
				pal_q      <= pal_n;
				trns_q     <= trns_n;
				sig_bad_q  <= sig_bad_n;
				ihdr_bad_q <= ihdr_bad_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_status_q <= res_status;
			// Error results carry all-zero fields.
			if (res_status == STATUS_OK) begin
				out_data_q <= {6'd0, res_reached, trns_n, pal_n, colour_n, height_n, width_n};
			end else begin
				out_data_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// Once the result of a file is given, no further result comes from it.
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (phase_q == PH_DONE) |-> !emit)
		else $error("scanner emitted a result after the file was finished");

	// An error result never carries field data.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != STATUS_OK) |-> (m_axis_tdata == '0))
		else $error("error result carries nonzero fields");

	// The end of a file puts the scanner back at the start of a header.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> (phase_q == PH_HEADER) && (idx_q == '0))
		else $error("scanner did not restart after the last byte");

	// A chunk body skip always has bytes left to count.
	a_skip_live: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_q != '0))
		else $error("skip phase with zero remaining count");

endmodule

### rtl/core/pnghs_byte_decode.sv
// ----------------------------------------------------------------------------
// PNG header scanner byte decoder
// Classifies the current byte by its header position and compares it with the
// expected signature and IHDR bytes; also classifies a completed chunk type.
// ----------------------------------------------------------------------------
module pnghs_byte_decode
	import pnghs_pkg::*;
(
	input  logic [HDR_IDX_W-1:0] idx,
	input  logic [7:0]           data,
	input  logic [23:0]          type_low,
	output byte_decode_t         dec
);

	logic [7:0]  sig_byte;
	logic [7:0]  ihdr_byte;
	logic [31:0] type_word;

	assign sig_byte  = SIG_CODE[{idx[2:0], 3'b000} +: 8];
	assign ihdr_byte = TYPE_IHDR[{idx[1:0], 3'b000} +: 8];

	// The type word is complete once its fourth byte is on the input.
	assign type_word = {data, type_low};

	always_comb begin
		dec.sig_mismatch  = (idx inside {[6'd0:6'd7]}) && (sig_byte != data);
		dec.ihdr_mismatch = (idx inside {[6'd12:6'd15]}) && (ihdr_byte != data);
		dec.width_byte    = idx inside {[6'd16:6'd19]};
		dec.height_byte   = idx inside {[6'd20:6'd23]};
		dec.colour_byte   = (idx == HDR_COLOUR_IDX);
		dec.header_end    = (idx >= HDR_LAST_IDX);
		dec.is_idat       = (type_word == TYPE_IDAT);
		dec.is_plte       = (type_word == TYPE_PLTE);
		dec.is_trns       = (type_word == TYPE_TRNS);
	end

endmodule
